[sv/mqlb_pkg.sv]
// package for the multi-queue linked buffer
// holds sizes, codes, beat types and the link reset function; no dependencies
package mqlb_pkg;

  localparam int NUM_QUEUES = 10;
  localparam int POOL_DEPTH = 256;

  localparam int PTR_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QID_W  = 4;
  localparam int KEY_W  = 32;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [QIDX_W-1:0] qidx_t;

  typedef struct packed {
    logic                     kind;
    logic [QID_W-1:0]         queue_id;
    logic signed [KEY_W-1:0]  key_in;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [KEY_W-1:0]  key_out;
  } result_t;

  // one queue's descriptor
  typedef struct packed {
    ptr_t head;
    ptr_t tail;
    logic nonempty;
  } qdesc_t;

  // update of one queue's descriptor
  typedef struct packed {
    qidx_t idx;
    logic  head_we;
    ptr_t  head;
    logic  tail_we;
    ptr_t  tail;
    logic  ne_we;
    logic  nonempty;
  } qwrite_t;

  // link value of an entry that was never written: the next entry, wrapping
  function automatic ptr_t link_reset_val(input ptr_t addr);
    ptr_t r;
    if (addr == PTR_W'(POOL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = addr + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

[sv/mqlb_key_ram.sv]
// key store of the shared entry pool
// one write port, one registered read port; uses mqlb_pkg
module mqlb_key_ram (
  input  logic                         clk,
  input  logic                         rd_en,
  input  mqlb_pkg::ptr_t               rd_addr,
  output logic signed [mqlb_pkg::KEY_W-1:0] rd_data,
  input  logic                         we,
  input  mqlb_pkg::ptr_t               wr_addr,
  input  logic signed [mqlb_pkg::KEY_W-1:0] wr_data
);
  import mqlb_pkg::*;

  logic signed [KEY_W-1:0] mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/mqlb_link_ram.sv]
// link store of the shared entry pool, with per-entry valid bits
// unwritten entries read as the next entry index; uses mqlb_pkg
module mqlb_link_ram (
  input  logic           clk,
  input  logic           rst,
  input  logic           rd_en,
  input  mqlb_pkg::ptr_t rd_addr,
  output mqlb_pkg::ptr_t rd_link,
  input  logic           we,
  input  mqlb_pkg::ptr_t wr_addr,
  input  mqlb_pkg::ptr_t wr_data
);
  import mqlb_pkg::*;

  ptr_t                  mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] vld;
  ptr_t                  rd_data;
  ptr_t                  rd_addr_q;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_link = rd_vld ? rd_data : link_reset_val(rd_addr_q);

endmodule

[sv/mqlb_qtab.sv]
// per-queue head, tail and nonempty registers
// one combinational read, one update per cycle; uses mqlb_pkg
module mqlb_qtab (
  input  logic              clk,
  input  logic              rst,
  input  mqlb_pkg::qidx_t   rd_idx,
  output mqlb_pkg::qdesc_t  rd_desc,
  input  logic              we,
  input  mqlb_pkg::qwrite_t wr
);
  import mqlb_pkg::*;

  ptr_t                  head [NUM_QUEUES];
  ptr_t                  tail [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
      nonempty <= '0;
    end else if (we) begin
      if (wr.head_we) begin
        head[wr.idx] <= wr.head;
      end
      if (wr.tail_we) begin
        tail[wr.idx] <= wr.tail;
      end
      if (wr.ne_we) begin
        nonempty[wr.idx] <= wr.nonempty;
      end
    end
  end

  assign rd_desc.head     = head[rd_idx];
  assign rd_desc.tail     = tail[rd_idx];
  assign rd_desc.nonempty = nonempty[rd_idx];

endmodule

[sv/multi_queue_linked_buffer.sv]
// multi-queue linked buffer: NUM_QUEUES fifos over one linked pool of POOL_DEPTH entries
// an accepted beat passes a read state (registered link/key read) and then an update state
// that registers the result; the next beat enters only as it commits, after the output frees
// reset: synchronous rst empties all queues, chains the whole pool as the free list
// (valid bits on the link store, no clearing pass); the block is ready right after reset
module multi_queue_linked_buffer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mqlb_pkg::item_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mqlb_pkg::result_t out_data
);
  import mqlb_pkg::*;

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] stage;
  logic [1:0] stage_next;
  item_t      item;
  ptr_t       free_head;
  ptr_t       free_head_next;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] free_count_next;

  logic    in_fire;
  logic    out_free;
  logic    fire_wr;
  logic    in_range;
  qidx_t   qidx;
  qdesc_t  desc;
  qwrite_t qwr;
  logic    enq_ok;
  logic    deq_ok;
  logic    rd_en;
  ptr_t    link_rd_addr;
  ptr_t    link_val;
  logic    link_we;
  ptr_t    link_wr_addr;
  logic signed [KEY_W-1:0] key_rd;
  result_t res;

  // handshake: the output register frees up when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign fire_wr  = (stage == ST_WRITE) && out_free;
  // next beat enters as soon as the current update commits
  assign in_ready = (stage == ST_IDLE) || fire_wr;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    stage_next = stage;
    unique case (stage)
      ST_IDLE:  if (in_fire) stage_next = ST_READ;
      ST_READ:  stage_next = ST_WRITE;
      ST_WRITE: if (fire_wr) stage_next = in_fire ? ST_READ : ST_IDLE;
      default:  stage_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= ST_IDLE;
    end else begin
      stage <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
  end

  // queue number decode; out-of-range numbers read queue zero but never commit
  assign in_range = int'(item.queue_id) < NUM_QUEUES;
  assign qidx     = in_range ? QIDX_W'(item.queue_id) : '0;

  mqlb_qtab u_qtab (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (qidx),
    .rd_desc (desc),
    .we      (fire_wr),
    .wr      (qwr)
  );

  // read cycle: link of the free head (enqueue) or queue head (dequeue), key of queue head
  assign rd_en        = (stage == ST_READ);
  assign link_rd_addr = (item.kind == KIND_ENQ) ? free_head : desc.head;

  mqlb_link_ram u_link (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (link_rd_addr),
    .rd_link (link_val),
    .we      (link_we),
    .wr_addr (link_wr_addr),
    .wr_data (free_head)
  );

  mqlb_key_ram u_key (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (desc.head),
    .rd_data (key_rd),
    .we      (fire_wr && enq_ok),
    .wr_addr (free_head),
    .wr_data (item.key_in)
  );

  // update cycle
  assign enq_ok = (item.kind == KIND_ENQ) && in_range && (free_count != '0);
  assign deq_ok = (item.kind == KIND_DEQ) && in_range && desc.nonempty;

  // enqueue onto a busy queue links the old tail to the new entry;
  // dequeue pushes the freed entry onto the free list
  assign link_we      = fire_wr && ((enq_ok && desc.nonempty) || deq_ok);
  assign link_wr_addr = deq_ok ? desc.head : desc.tail;

  always_comb begin
    qwr          = '0;
    qwr.idx      = qidx;
    qwr.head     = free_head;
    qwr.tail     = free_head;
    qwr.nonempty = 1'b1;
    if (enq_ok) begin
      qwr.head_we = !desc.nonempty;
      qwr.tail_we = 1'b1;
      qwr.ne_we   = 1'b1;
    end else if (deq_ok) begin
      if (desc.head == desc.tail) begin
        // last entry leaves
        qwr.ne_we    = 1'b1;
        qwr.nonempty = 1'b0;
      end else begin
        qwr.head_we = 1'b1;
        qwr.head    = link_val;
      end
    end
  end

  always_comb begin
    free_head_next  = free_head;
    free_count_next = free_count;
    if (enq_ok) begin
      free_head_next  = link_val;
      free_count_next = free_count - CNT_W'(1);
    end else if (deq_ok) begin
      free_head_next = desc.head;
      if (free_count < CNT_W'(POOL_DEPTH)) begin
        free_count_next = free_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      free_count <= CNT_W'(POOL_DEPTH);
    end else if (fire_wr) begin
      free_head  <= free_head_next;
      free_count <= free_count_next;
    end
  end

  // result beat
  always_comb begin
    res.key_out = '0;
    if (item.kind == KIND_ENQ) begin
      res.status = enq_ok ? STAT_OK : STAT_FULL;
    end else begin
      res.status = deq_ok ? STAT_OK : STAT_EMPTY;
      if (deq_ok) begin
        res.key_out = key_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire_wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_wr) begin
      out_data <= res;
    end
  end

  // checks
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (rst)
    (stage == ST_READ) |-> !in_ready)
    else $error("beat accepted while memory read in flight");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage == ST_WRITE))
    else $error("result beat without an update cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(POOL_DEPTH))
    else $error("free count above pool depth");

  a_enq_takes_entry: assert property (@(posedge clk) disable iff (rst)
    (fire_wr && enq_ok) |=> (free_count == $past(free_count) - CNT_W'(1)))
    else $error("enqueue did not take a free entry");

endmodule

[test/multi_queue_linked_buffer_tb.sv]
// self-checking testbench for the multi-queue linked buffer
// holds its own model of queues, links and free list; depends on mqlb_pkg and the block only
`timescale 1ns / 100ps

module multi_queue_linked_buffer_tb;
  import mqlb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QID_MAX     = (1 << QID_W) - 1;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  item_t   in_data   = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_data;

  // while set, neither side inserts idle cycles
  logic steady = 1'b0;

  int cycle_count = 0;
  int errors      = 0;

  // model of the block: queue descriptors, link and key stores, free list
  ptr_t                    q_head     [NUM_QUEUES];
  ptr_t                    q_tail     [NUM_QUEUES];
  logic                    q_nonempty [NUM_QUEUES];
  ptr_t                    link_mem   [POOL_DEPTH];
  logic signed [KEY_W-1:0] key_mem    [POOL_DEPTH];
  ptr_t                    free_head;
  logic [CNT_W-1:0]        free_left;

  // results still owed by the block, oldest first
  result_t pending_results[$];

  // outcome tallies for the summary
  int n_enq_ok = 0;
  int n_full   = 0;
  int n_deq_ok = 0;
  int n_empty  = 0;

  multi_queue_linked_buffer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("multi_queue_linked_buffer regression: fail");
      $finish;
    end
  end

  // receiver back-pressure: stalls with a chance of about 28 percent unless steady
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 28);
  end

  // result checker: every result beat is matched against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d key_out %0d",
               out_data.status, out_data.key_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.key_out !== want.key_out) begin
          $error("key_out: expected %0d, got %0d", want.key_out, out_data.key_out);
          errors++;
        end
      end
    end
  end

  // model state after reset: empty queues, whole pool chained as the free list
  task automatic clear_model();
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head[i]     = '0;
      q_tail[i]     = '0;
      q_nonempty[i] = 1'b0;
    end
    for (int i = 0; i < POOL_DEPTH; i++) begin
      link_mem[i] = (i == POOL_DEPTH - 1) ? ptr_t'(0) : ptr_t'(i + 1);
      key_mem[i]  = '0;
    end
    free_head = '0;
    free_left = CNT_W'(POOL_DEPTH);
  endtask

  // applies one operation to the model and returns the result the block owes
  function automatic result_t predict_result(input item_t beat);
    result_t r;
    ptr_t    slot;
    qidx_t   q;
    r.status  = STAT_OK;
    r.key_out = '0;
    q = qidx_t'(beat.queue_id);
    if (beat.kind == KIND_ENQ) begin
      // out-of-range queues have no capacity, so they look full
      if (beat.queue_id >= NUM_QUEUES || free_left == 0) begin
        r.status = STAT_FULL;
        n_full++;
      end else begin
        slot          = free_head;
        free_head     = link_mem[slot];
        free_left     = free_left - 1'b1;
        key_mem[slot] = beat.key_in;
        if (q_nonempty[q]) begin
          link_mem[q_tail[q]] = slot;
        end else begin
          q_head[q] = slot;
        end
        q_tail[q]     = slot;
        q_nonempty[q] = 1'b1;
        n_enq_ok++;
      end
    end else begin
      if (beat.queue_id >= NUM_QUEUES || !q_nonempty[q]) begin
        r.status = STAT_EMPTY;
        n_empty++;
      end else begin
        slot      = q_head[q];
        r.key_out = key_mem[slot];
        // removing the last entry only clears the nonempty bit
        if (slot == q_tail[q]) begin
          q_nonempty[q] = 1'b0;
        end else begin
          q_head[q] = link_mem[slot];
        end
        // freed entry goes back on the front of the free list
        link_mem[slot] = free_head;
        free_head      = slot;
        if (free_left < POOL_DEPTH) begin
          free_left = free_left + 1'b1;
        end
        n_deq_ok++;
      end
    end
    return r;
  endfunction

  function automatic item_t make_beat(input logic kind, input int qid,
                                      input logic [KEY_W-1:0] key);
    item_t b;
    b.kind     = kind;
    b.queue_id = QID_W'(qid);
    b.key_in   = key;
    return b;
  endfunction

  // drives one beat, with a random idle gap in front, and records its expected result
  // entered and left right after a rising edge; valid stays high into the next beat
  task automatic send_beat(input item_t beat);
    if (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 28);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(beat));
  endtask

  // empty-queue dequeue, key extremes, fifo order and removal of the last entry
  task automatic test_extremes();
    send_beat(make_beat(KIND_DEQ, 0, 32'h0000_0000));
    send_beat(make_beat(KIND_ENQ, 0, 32'h7fff_ffff));
    send_beat(make_beat(KIND_ENQ, 0, 32'h8000_0000));
    send_beat(make_beat(KIND_ENQ, NUM_QUEUES - 1, 32'h0000_0000));
    send_beat(make_beat(KIND_ENQ, NUM_QUEUES - 1, 32'hffff_ffff));
    send_beat(make_beat(KIND_DEQ, 0, 32'hffff_ffff));   // key_in ignored on dequeue
    send_beat(make_beat(KIND_DEQ, 0, 32'h0000_0000));
    send_beat(make_beat(KIND_DEQ, 0, 32'h0000_0000));   // queue is empty again
    send_beat(make_beat(KIND_DEQ, NUM_QUEUES - 1, 32'h0000_0000));
    send_beat(make_beat(KIND_DEQ, NUM_QUEUES - 1, 32'h0000_0000));
    send_beat(make_beat(KIND_DEQ, NUM_QUEUES - 1, 32'h0000_0000));
  endtask

  // queue numbers past the last queue: enqueue reports full, dequeue reports empty
  task automatic test_out_of_range();
    send_beat(make_beat(KIND_ENQ, NUM_QUEUES, 32'h1234_5678));
    send_beat(make_beat(KIND_ENQ, QID_MAX, 32'hdead_beef));
    send_beat(make_beat(KIND_DEQ, NUM_QUEUES, 32'h0000_0000));
    send_beat(make_beat(KIND_DEQ, QID_MAX, 32'h5555_aaaa));
  endtask

  // several queues interleaved so their chains share the pool
  task automatic test_interleave();
    send_beat(make_beat(KIND_ENQ, 3, 32'h0000_0003));
    send_beat(make_beat(KIND_ENQ, 5, 32'h0000_0005));
    send_beat(make_beat(KIND_ENQ, 3, 32'h0000_0033));
    send_beat(make_beat(KIND_ENQ, 5, 32'h0000_0055));
    send_beat(make_beat(KIND_DEQ, 3, 32'h0000_0000));
    send_beat(make_beat(KIND_DEQ, 5, 32'h0000_0000));
    send_beat(make_beat(KIND_DEQ, 3, 32'h0000_0000));
    send_beat(make_beat(KIND_DEQ, 5, 32'h0000_0000));
  endtask

  // fills the whole pool, pushes past full, then drains every queue
  task automatic test_pool_full();
    int qid;
    steady = 1'b1;   // long stretch with no idling on either side
    while (free_left != 0) begin
      send_beat(make_beat(KIND_ENQ, $urandom_range(NUM_QUEUES - 1), $urandom));
    end
    steady = 1'b0;
    repeat (3) begin
      send_beat(make_beat(KIND_ENQ, $urandom_range(NUM_QUEUES - 1), $urandom));
    end
    // one entry freed from the full pool and taken again
    qid = $urandom_range(NUM_QUEUES - 1);
    while (!q_nonempty[qid]) qid = (qid + 1) % NUM_QUEUES;
    send_beat(make_beat(KIND_DEQ, qid, $urandom));
    send_beat(make_beat(KIND_ENQ, $urandom_range(NUM_QUEUES - 1), $urandom));
    send_beat(make_beat(KIND_ENQ, $urandom_range(NUM_QUEUES - 1), $urandom));
    for (int q = 0; q < NUM_QUEUES; q++) begin
      while (q_nonempty[q]) send_beat(make_beat(KIND_DEQ, q, $urandom));
    end
  endtask

  // random mix in phases that push the pool toward full and back toward empty
  task automatic test_random_traffic();
    int   enq_pct[5] = '{90, 10, 65, 35, 50};
    int   hot;
    int   qid;
    logic kind;
    for (int p = 0; p < 5; p++) begin
      hot = $urandom_range(NUM_QUEUES - 1);
      repeat (132) begin
        if ($urandom_range(99) < 8) begin
          qid = $urandom_range(QID_MAX, NUM_QUEUES);
        end else if ($urandom_range(99) < 40) begin
          qid = hot;   // favor one queue so long chains form
        end else begin
          qid = $urandom_range(NUM_QUEUES - 1);
        end
        kind = ($urandom_range(99) < enq_pct[p]) ? KIND_ENQ : KIND_DEQ;
        send_beat(make_beat(kind, qid, $urandom));
      end
    end
  endtask

  initial begin
    clear_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_out_of_range();
    test_interleave();
    test_pool_full();
    test_random_traffic();
    in_valid <= 1'b0;

    // drain, then keep the clock running to catch stray result beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d enqueues, %0d full rejects, %0d dequeues, %0d empty rejects",
             n_enq_ok, n_full, n_deq_ok, n_empty);
    $display("pool exhausted and drained, %0d cycles, %0d mismatches", cycle_count, errors);
    if (errors == 0) begin
      $display("multi_queue_linked_buffer regression: pass");
    end else begin
      $display("multi_queue_linked_buffer regression: fail");
    end
    $finish;
  end

endmodule
